// File: hw/rtl/tricycle_steer_and_speed_unit_defines.svh
// Assertion macros used by the checker file of the steering and speed unit.
`ifndef TRICYCLE_STEER_AND_SPEED_UNIT_DEFINES_SVH
`define TRICYCLE_STEER_AND_SPEED_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSU_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsu assertion failed");

`endif

// File: hw/rtl/tsu_pkg.sv
`default_nettype none

package tsu_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 14;
  localparam int unsigned TAB_LEN           = 24;
  localparam int unsigned PIPE_FIXED_STAGES = 5;

  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned ANGLE_W    = 14;
  localparam int unsigned WB_W       = 14;
  localparam int unsigned PCT_W      = 8;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FRAC_W     = 12;

  localparam int unsigned XW       = 32;
  localparam int unsigned ZW       = 27;
  localparam int unsigned GAIN_W   = 30;
  localparam int unsigned GAIN_SH  = 30;
  localparam int unsigned MAG_W    = 30;
  localparam int unsigned NUM_W    = 39;
  localparam int unsigned N_W      = 26;
  localparam int unsigned RECIP_W  = 27;
  localparam int unsigned RECIP_SH = 33;
  localparam int unsigned Q_W      = 20;

  localparam logic [GAIN_W-1:0]  INV_GAIN     = 30'd652032874;
  localparam logic [RECIP_W-1:0] RECIP_100    = 27'd85899346;
  localparam logic [RECIP_W-1:0] RECIP_125    = 27'd68719477;
  localparam logic [NUM_W-1:0]   HALF_DEN_100 = 39'd204800;
  localparam logic [NUM_W-1:0]   HALF_DEN_125 = 39'd256000;

  localparam int ROUND_HALF  = 2048;
  localparam int ANGLE_MAX   = 8191;
  localparam int ANGLE_MIN   = -8192;
  localparam int SLOW_ANGLE  = 1024;
  localparam int SPEED_LIMIT = 32768;
  localparam int SPEED_MAX   = 32767;
  localparam int CAP_HIGH    = 1229;
  localparam int CAP_LOW     = 614;

  localparam logic [WB_W-1:0]           WHEELBASE_RST   = 14'd4653;
  localparam logic [PCT_W-1:0]          PERCENT_RST     = 8'd100;
  localparam logic signed [ANGLE_W-1:0] STOP_ANGLE_RST  = 14'sd0;
  localparam logic [MODE_W-1:0]         MANUAL_MODE_RST = 2'd0;
  localparam logic [MODE_W-1:0]         STOP_MODE_RST   = 2'd0;

  localparam logic [MODE_W-1:0] MANUAL_AUTO   = 2'd0;
  localparam logic [MODE_W-1:0] MANUAL_FORCE  = 2'd1;
  localparam logic [MODE_W-1:0] STOP_FULL     = 2'd1;
  localparam logic [MODE_W-1:0] STOP_CAP_HIGH = 2'd2;
  localparam logic [MODE_W-1:0] STOP_CAP_LOW  = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHEELBASE,
    REG_SPEED_PERCENT,
    REG_STOP_ANGLE,
    REG_MANUAL_MODE,
    REG_STOP_MODE,
    REG_SECOND_STOP
  } cfg_reg_e;

  typedef struct packed {
    logic [WB_W-1:0]           wheelbase;
    logic [PCT_W-1:0]          speed_percent;
    logic signed [ANGLE_W-1:0] stop_angle;
    logic [MODE_W-1:0]         manual_mode;
    logic [MODE_W-1:0]         stop_mode;
    logic                      second_stop;
  } cfg_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
    logic                 zero;
  } cordic_t;

  localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
    27'sd13176795, 27'sd7778716, 27'sd4110060, 27'sd2086331,
    27'sd1047514, 27'sd524117, 27'sd262123, 27'sd131069,
    27'sd65536, 27'sd32768, 27'sd16384, 27'sd8192,
    27'sd4096, 27'sd2048, 27'sd1024, 27'sd512,
    27'sd256, 27'sd128, 27'sd64, 27'sd32,
    27'sd16, 27'sd8, 27'sd4, 27'sd2
  };

endpackage

`default_nettype wire

// File: hw/rtl/tsu_if.sv
`default_nettype none

interface tsu_cmd_if;
  import tsu_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] fwd_speed;
  logic signed [SPEED_W-1:0] yaw_rate;
  modport source (output valid, output fwd_speed, output yaw_rate, input ready);
  modport sink (input valid, input fwd_speed, input yaw_rate, output ready);
endinterface

interface tsu_res_if;
  import tsu_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] wheel_speed;
  logic signed [ANGLE_W-1:0] steer_angle;
  modport source (output valid, output wheel_speed, output steer_angle, input ready);
  modport sink (input valid, input wheel_speed, input steer_angle, output ready);
endinterface

interface tsu_cfg_if;
  import tsu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tsu_prep.sv
`default_nettype none

module tsu_prep (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [tsu_pkg::SPEED_W-1:0] fwd_speed_i,
  input  logic signed [tsu_pkg::SPEED_W-1:0] yaw_rate_i,
  input  logic [tsu_pkg::WB_W-1:0]           wheelbase_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output tsu_pkg::cordic_t                   data_o
);
  import tsu_pkg::*;

  logic                         valid_q;
  cordic_t                      data_q;
  cordic_t                      data_d;
  logic                         neg;
  logic signed [SPEED_W:0]      abs_v;
  logic signed [WB_W+SPEED_W:0] prod;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // The vector is mirrored into the right half plane by the sign of the speed.
  always_comb begin
    neg      = fwd_speed_i[SPEED_W-1];
    abs_v    = neg ? -(SPEED_W+1)'(fwd_speed_i) : (SPEED_W+1)'(fwd_speed_i);
    prod     = $signed({1'b0, wheelbase_i}) * yaw_rate_i;
    data_d.x = XW'(abs_v) << FRAC_W;
    data_d.y = neg ? -XW'(prod) : XW'(prod);
    data_d.z = '0;
    data_d.neg  = neg;
    data_d.zero = (fwd_speed_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tsu_cordic.sv
`default_nettype none

module tsu_cordic #(
  parameter int unsigned STAGES = tsu_pkg::CORDIC_STAGES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  tsu_pkg::cordic_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output tsu_pkg::cordic_t data_o
);
  import tsu_pkg::*;

  logic [STAGES-1:0] valid_q;
  logic [STAGES:0]   adv;
  cordic_t           stage_q [STAGES];

  function automatic cordic_t rotate(cordic_t s, int unsigned sh,
                                     logic signed [ZW-1:0] step);
    cordic_t              r;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    r  = s;
    dx = $signed(s.y) >>> sh;
    dy = $signed(s.x) >>> sh;
    if (!s.y[XW-1] && (s.y != '0)) begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.z = s.z + step;
    end else begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.z = s.z - step;
    end
    return r;
  endfunction

  assign adv[STAGES] = ready_i;
  assign ready_o     = adv[0];
  assign valid_o     = valid_q[STAGES-1];
  assign data_o      = stage_q[STAGES-1];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN_STEP = ATAN_TAB[i];

    cordic_t in_s;
    logic    in_v;

    if (i == 0) begin : g_first
      assign in_s = data_i;
      assign in_v = valid_i;
    end else begin : g_next
      assign in_s = stage_q[i-1];
      assign in_v = valid_q[i-1];
    end

    assign adv[i] = !valid_q[i] || adv[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (adv[i]) begin
        valid_q[i] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[i] && in_v) begin
        stage_q[i] <= rotate(in_s, i, ATAN_STEP);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tsu_scale.sv
`default_nettype none

module tsu_scale (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tsu_pkg::cfg_t                      cfg_i,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  tsu_pkg::cordic_t                   data_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic signed [tsu_pkg::SPEED_W-1:0] wheel_speed_o,
  output logic signed [tsu_pkg::ANGLE_W-1:0] steer_angle_o
);
  import tsu_pkg::*;

  localparam int unsigned GPROD_W = XW - 1 + GAIN_W;
  localparam int unsigned RPROD_W = N_W + RECIP_W;

  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  logic a_adv, b_adv, c_adv, d_adv;

  logic [MAG_W-1:0]          a_mag_q;
  logic signed [ANGLE_W-1:0] a_angle_q;
  logic                      a_slow_q, a_neg_q, a_zero_q;
  logic [N_W-1:0]            b_n_q;
  logic signed [ANGLE_W-1:0] b_angle_q;
  logic                      b_slow_q, b_neg_q, b_zero_q;
  logic [Q_W-1:0]            c_q_q;
  logic signed [ANGLE_W-1:0] c_angle_q;
  logic                      c_neg_q, c_zero_q;
  logic signed [SPEED_W-1:0] d_speed_q;
  logic signed [ANGLE_W-1:0] d_angle_q;

  logic [GPROD_W-1:0]        gain_prod;
  logic signed [ZW:0]        z_rnd;
  logic signed [ZW:0]        z_q12;
  logic signed [ANGLE_W-1:0] angle_d;
  logic                      slow_d;
  logic [NUM_W-1:0]          num;
  logic [RPROD_W-1:0]        recip_prod;
  logic [Q_W-1:0]            q_sat;
  logic signed [SPEED_W:0]   spd_neg;
  logic signed [SPEED_W-1:0] speed_d;

  assign d_adv   = !d_valid_q || ready_i;
  assign c_adv   = !c_valid_q || d_adv;
  assign b_adv   = !b_valid_q || c_adv;
  assign a_adv   = !a_valid_q || b_adv;
  assign ready_o = a_adv;

  assign valid_o       = d_valid_q;
  assign wheel_speed_o = d_speed_q;
  assign steer_angle_o = d_angle_q;

  // Gain correction, angle rounding and clamping, the stop angle at zero speed and the slow-turn flag.
  always_comb begin
    gain_prod = GPROD_W'(data_i.x[XW-2:0]) * GPROD_W'(INV_GAIN);
    z_rnd     = $signed({data_i.z[ZW-1], data_i.z}) + $signed((ZW+1)'(ROUND_HALF));
    z_q12     = z_rnd >>> FRAC_W;
    if (z_q12 > ANGLE_MAX) begin
      angle_d = ANGLE_W'(ANGLE_MAX);
    end else if (z_q12 < ANGLE_MIN) begin
      angle_d = ANGLE_W'(ANGLE_MIN);
    end else begin
      angle_d = z_q12[ANGLE_W-1:0];
    end
    if (data_i.zero) begin
      angle_d = cfg_i.stop_angle;
    end
    slow_d = (angle_d > SLOW_ANGLE) || (angle_d < -SLOW_ANGLE);
  end

  // Percent scaling with the rounding offset of the chosen divisor.
  always_comb begin
    num = NUM_W'(a_mag_q) * NUM_W'(cfg_i.speed_percent)
        + (a_slow_q ? HALF_DEN_125 : HALF_DEN_100);
  end

  // Division by 100 or 125 through a rounded-up reciprocal.
  always_comb begin
    recip_prod = RPROD_W'(b_n_q) * RPROD_W'(b_slow_q ? RECIP_125 : RECIP_100);
  end

  // Saturation, sign and the mode rules.
  always_comb begin
    q_sat   = (c_q_q > Q_W'(SPEED_LIMIT)) ? Q_W'(SPEED_LIMIT) : c_q_q;
    spd_neg = -$signed((SPEED_W+1)'(q_sat));
    if (c_neg_q) begin
      speed_d = spd_neg[SPEED_W-1:0];
    end else if (q_sat >= Q_W'(SPEED_MAX)) begin
      speed_d = SPEED_W'(SPEED_MAX);
    end else begin
      speed_d = q_sat[SPEED_W-1:0];
    end
    if (c_zero_q) begin
      speed_d = '0;
    end
    case (cfg_i.manual_mode)
      MANUAL_FORCE: begin
        speed_d = '0;
      end
      MANUAL_AUTO: begin
        if (cfg_i.stop_mode == STOP_CAP_HIGH && cfg_i.speed_percent != '0) begin
          if (speed_d > CAP_HIGH) begin
            speed_d = SPEED_W'(CAP_HIGH);
          end
        end else if (cfg_i.stop_mode == STOP_CAP_LOW && cfg_i.speed_percent != '0) begin
          if (speed_d > CAP_LOW) begin
            speed_d = SPEED_W'(CAP_LOW);
          end
        end else if (cfg_i.stop_mode == STOP_FULL) begin
          speed_d = '0;
        end
        if (cfg_i.second_stop) begin
          speed_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_q <= valid_i;
      end
      if (b_adv) begin
        b_valid_q <= a_valid_q;
      end
      if (c_adv) begin
        c_valid_q <= b_valid_q;
      end
      if (d_adv) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && valid_i) begin
      a_mag_q   <= gain_prod[GAIN_SH +: MAG_W];
      a_angle_q <= angle_d;
      a_slow_q  <= slow_d;
      a_neg_q   <= data_i.neg;
      a_zero_q  <= data_i.zero;
    end
    if (b_adv && a_valid_q) begin
      b_n_q     <= num[FRAC_W +: N_W];
      b_angle_q <= a_angle_q;
      b_slow_q  <= a_slow_q;
      b_neg_q   <= a_neg_q;
      b_zero_q  <= a_zero_q;
    end
    if (c_adv && b_valid_q) begin
      c_q_q     <= recip_prod[RECIP_SH +: Q_W];
      c_angle_q <= b_angle_q;
      c_neg_q   <= b_neg_q;
      c_zero_q  <= b_zero_q;
    end
    if (d_adv && c_valid_q) begin
      d_speed_q <= speed_d;
      d_angle_q <= c_angle_q;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tricycle_steer_and_speed_unit.sv
// An accepted request passes through the prep register, the CORDIC stage registers and the
// scale stages a to d. Throughput: one request per cycle unless the output stalls; every
// CORDIC iteration and every multiply has its own register stage, and the final output
// register holds a result until it is taken. Reset clears all stage valid bits at once and
// loads the register reset values; requests are accepted in the first cycle after reset.
`default_nettype none

module tricycle_steer_and_speed_unit #(
  parameter int unsigned CORDIC_STAGES = tsu_pkg::CORDIC_STAGES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsu_cmd_if.sink   cmd_i,
  tsu_res_if.source res_o,
  tsu_cfg_if.sink   cfg_i
);
  import tsu_pkg::*;

  cfg_t    cfg_q;
  cordic_t prep_data;
  cordic_t cordic_data;
  logic    prep_valid, prep_ready;
  logic    cordic_valid, cordic_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wheelbase     <= WHEELBASE_RST;
      cfg_q.speed_percent <= PERCENT_RST;
      cfg_q.stop_angle    <= STOP_ANGLE_RST;
      cfg_q.manual_mode   <= MANUAL_MODE_RST;
      cfg_q.stop_mode     <= STOP_MODE_RST;
      cfg_q.second_stop   <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_WHEELBASE:     cfg_q.wheelbase     <= cfg_i.data[WB_W-1:0];
        REG_SPEED_PERCENT: cfg_q.speed_percent <= cfg_i.data[PCT_W-1:0];
        REG_STOP_ANGLE:    cfg_q.stop_angle    <= $signed(cfg_i.data[ANGLE_W-1:0]);
        REG_MANUAL_MODE:   cfg_q.manual_mode   <= cfg_i.data[MODE_W-1:0];
        REG_STOP_MODE:     cfg_q.stop_mode     <= cfg_i.data[MODE_W-1:0];
        REG_SECOND_STOP:   cfg_q.second_stop   <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  tsu_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (cmd_i.valid),
    .ready_o     (cmd_i.ready),
    .fwd_speed_i (cmd_i.fwd_speed),
    .yaw_rate_i  (cmd_i.yaw_rate),
    .wheelbase_i (cfg_q.wheelbase),
    .valid_o     (prep_valid),
    .ready_i     (prep_ready),
    .data_o      (prep_data)
  );

  tsu_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .data_i  (prep_data),
    .valid_o (cordic_valid),
    .ready_i (cordic_ready),
    .data_o  (cordic_data)
  );

  tsu_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .valid_i       (cordic_valid),
    .ready_o       (cordic_ready),
    .data_i        (cordic_data),
    .valid_o       (res_o.valid),
    .ready_i       (res_o.ready),
    .wheel_speed_o (res_o.wheel_speed),
    .steer_angle_o (res_o.steer_angle)
  );

endmodule

`default_nettype wire

// File: hw/rtl/tsu_checker.sv
`default_nettype none
`include "tricycle_steer_and_speed_unit_defines.svh"

module tsu_checker #(
  parameter int unsigned STAGES = tsu_pkg::CORDIC_STAGES_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [tsu_pkg::SPEED_W-1:0] wheel_speed_i,
  input logic signed [tsu_pkg::ANGLE_W-1:0] steer_angle_i
);
  import tsu_pkg::*;

  localparam int unsigned LATENCY = STAGES + PIPE_FIXED_STAGES;
  localparam int unsigned CNT_W   = $clog2(LATENCY + 2);

  logic                       in_acc, out_acc, out_stall;
  logic [SPEED_W+ANGLE_W-1:0] res_bits;
  logic [CNT_W-1:0]           cnt_q;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_acc   = out_valid_i && out_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign res_bits  = {wheel_speed_i, steer_angle_i};

  // Requests accepted whose results have not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  `TSU_ASSERT_IMPL(a_no_spurious_result, clk_i, rst_ni, out_valid_i, cnt_q != '0)
  `TSU_ASSERT_IMPL(a_depth_bound, clk_i, rst_ni, in_acc, cnt_q <= CNT_W'(LATENCY))
  `TSU_ASSERT_IMPL(a_empty_latency, clk_i, rst_ni, in_acc && (cnt_q == '0), ##LATENCY out_valid_i)
  `TSU_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_stall, out_valid_i && $stable(res_bits))

endmodule

bind tricycle_steer_and_speed_unit tsu_checker #(
  .STAGES (CORDIC_STAGES)
) u_tsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (cmd_i.valid),
  .in_ready_i    (cmd_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .wheel_speed_i (res_o.wheel_speed),
  .steer_angle_i (res_o.steer_angle)
);

`default_nettype wire

// File: dv/tricycle_steer_and_speed_unit_test.sv
`default_nettype none

module tricycle_steer_and_speed_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tsu_pkg::*;

  localparam int LATENCY = CORDIC_STAGES_DEF + PIPE_FIXED_STAGES;
  localparam int SEGMENTS = 8;
  localparam int SEGMENT_ITEMS = 131;
  localparam int REPORT_LIMIT = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NONE  = 3'd7;
  localparam logic [MODE_W-1:0] MANUAL_FREE  = 2'd2;
  localparam logic [MODE_W-1:0] MANUAL_SPARE = 2'd3;
  localparam logic [MODE_W-1:0] STOP_NONE    = 2'd0;

  localparam longint INV_K_Q30 = 652032874;
  localparam longint ARC_STEP_Q24 [0:23] = '{
    13176795, 7778716, 4110060, 2086331, 1047514, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic signed [ANGLE_W-1:0] angle;
  } steer_result_t;

  typedef struct {
    int wheelbase;
    int percent;
    int stop_angle;
    int manual;
    int stop;
    int second;
  } drive_regs_t;

  typedef struct packed {
    logic                      is_write;
    logic [CFG_IDX_W-1:0]      reg_idx;
    logic [CFG_DATA_W-1:0]     reg_data;
    logic signed [SPEED_W-1:0] fwd;
    logic signed [SPEED_W-1:0] yaw;
    logic                      typed;
    steer_result_t             known;
  } drill_row_t;

  logic clk = 1'b0;
  logic rst_n;

  tsu_cmd_if cmd_if ();
  tsu_res_if res_if ();
  tsu_cfg_if cfg_if ();

  tricycle_steer_and_speed_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #10 clk = ~clk;

  drive_regs_t   drive_regs;
  steer_result_t pending_results[$];
  drill_row_t    drill_rows[$];
  int            send_idle_pct;
  int            stall_pct;
  int            fail_count;
  int            commands_sent;
  int            results_seen;
  int            writes_done;
  int            slow_turns;

  function automatic void add_cmd(logic signed [SPEED_W-1:0] fwd,
                                  logic signed [SPEED_W-1:0] yaw);
    drill_row_t row;
    row = '0;
    row.fwd = fwd;
    row.yaw = yaw;
    drill_rows.push_back(row);
  endfunction

  function automatic void add_known(logic signed [SPEED_W-1:0] fwd,
                                    logic signed [SPEED_W-1:0] yaw,
                                    logic signed [SPEED_W-1:0] speed,
                                    logic signed [ANGLE_W-1:0] angle);
    drill_row_t row;
    row = '0;
    row.fwd = fwd;
    row.yaw = yaw;
    row.typed = 1'b1;
    row.known.speed = speed;
    row.known.angle = angle;
    drill_rows.push_back(row);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drill_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_data = data;
    drill_rows.push_back(row);
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WHEELBASE:     drive_regs.wheelbase = int'(data[WB_W-1:0]);
      REG_SPEED_PERCENT: drive_regs.percent = int'(data[PCT_W-1:0]);
      REG_STOP_ANGLE:    drive_regs.stop_angle = int'($signed(data[ANGLE_W-1:0]));
      REG_MANUAL_MODE:   drive_regs.manual = int'(data[MODE_W-1:0]);
      REG_STOP_MODE:     drive_regs.stop = int'(data[MODE_W-1:0]);
      REG_SECOND_STOP:   drive_regs.second = int'(data[0]);
      default: ;
    endcase
  endfunction

  function automatic steer_result_t predict_steering(logic signed [SPEED_W-1:0] fwd,
                                                     logic signed [SPEED_W-1:0] yaw);
    longint v, w, x, y, z, dx, dy, angle, mag, den, num, q, speed;
    int stages;
    bit neg;
    steer_result_t r;
    v = fwd;
    w = yaw;
    speed = 0;
    if (v == 0) begin
      angle = drive_regs.stop_angle;
    end else begin
      neg = v < 0;
      x = (neg ? -v : v) * 4096;
      y = longint'(drive_regs.wheelbase) * w;
      z = 0;
      if (neg) begin
        y = -y;
      end
      stages = CORDIC_STAGES_DEF > 24 ? 24 : CORDIC_STAGES_DEF;
      for (int i = 0; i < stages; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ARC_STEP_Q24[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ARC_STEP_Q24[i];
        end
      end
      angle = (z + ROUND_HALF) >>> FRAC_W;
      if (angle > ANGLE_MAX) angle = ANGLE_MAX;
      if (angle < ANGLE_MIN) angle = ANGLE_MIN;
      mag = (x * INV_K_Q30) >>> 30;
      if (angle > SLOW_ANGLE || angle < -SLOW_ANGLE) begin
        den = 125 * 4096;
        slow_turns++;
      end else begin
        den = 100 * 4096;
      end
      num = mag * drive_regs.percent + den / 2;
      q = num / den;
      if (q > SPEED_LIMIT) q = SPEED_LIMIT;
      speed = neg ? -q : q;
      if (speed > SPEED_MAX) speed = SPEED_MAX;
    end
    if (drive_regs.manual == MANUAL_FORCE) begin
      speed = 0;
    end else if (drive_regs.manual == MANUAL_AUTO) begin
      if (drive_regs.stop == STOP_CAP_HIGH && drive_regs.percent > 0) begin
        if (speed > CAP_HIGH) speed = CAP_HIGH;
      end else if (drive_regs.stop == STOP_CAP_LOW && drive_regs.percent > 0) begin
        if (speed > CAP_LOW) speed = CAP_LOW;
      end else if (drive_regs.stop == STOP_FULL) begin
        speed = 0;
      end
      if (drive_regs.second == 1) speed = 0;
    end
    r.speed = speed[SPEED_W-1:0];
    r.angle = angle[ANGLE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SPEED_W-1:0] pick_field(int zero_pct);
    int r;
    r = $urandom_range(99);
    if (r < zero_pct) return '0;
    if (r < zero_pct + 8) begin
      case ($urandom_range(3))
        0: return 16'sh8000;
        1: return 16'sh7FFF;
        2: return 16'sh0001;
        default: return 16'shFFFF;
      endcase
    end
    if (r < 55) return SPEED_W'(int'($urandom_range(16383)) - 8192);
    return SPEED_W'($urandom);
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] want,
                                 logic signed [31:0] got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // The write channel stays valid between back-to-back writes; the next request
  // to the command side lowers it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    apply_reg(idx, data);
    writes_done++;
    @(negedge clk);
  endtask

  task automatic send_cmd(drill_row_t row);
    cfg_if.valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.fwd_speed <= row.fwd;
    cmd_if.yaw_rate  <= row.yaw;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    pending_results.push_back(row.typed ? row.known : predict_steering(row.fwd, row.yaw));
    commands_sent++;
    @(negedge clk);
  endtask

  task automatic program_segment(int seg);
    logic [CFG_DATA_W-1:0] d_wb, d_pct, d_ang, d_man, d_stop, d_sec;
    d_wb   = CFG_DATA_W'($urandom);
    d_pct  = CFG_DATA_W'($urandom);
    d_ang  = CFG_DATA_W'($urandom);
    d_man  = CFG_DATA_W'($urandom);
    d_stop = CFG_DATA_W'($urandom);
    d_sec  = CFG_DATA_W'($urandom);
    case (seg)
      0: begin
        d_wb[WB_W-1:0] = WHEELBASE_RST;
        d_pct[PCT_W-1:0] = PERCENT_RST;
        d_ang[ANGLE_W-1:0] = STOP_ANGLE_RST;
        d_man[MODE_W-1:0] = MANUAL_AUTO;
        d_stop[MODE_W-1:0] = STOP_NONE;
        d_sec[0] = 1'b0;
      end
      1: begin
        d_wb[WB_W-1:0] = '1;
        d_pct[PCT_W-1:0] = '1;
        d_ang[ANGLE_W-1:0] = ANGLE_W'(ANGLE_MAX);
        d_man[MODE_W-1:0] = MANUAL_AUTO;
        d_stop[MODE_W-1:0] = STOP_NONE;
        d_sec[0] = 1'b0;
      end
      2: begin
        d_wb[WB_W-1:0] = '0;
        d_pct[PCT_W-1:0] = 8'd200;
        d_ang[ANGLE_W-1:0] = ANGLE_W'(ANGLE_MIN);
        d_man[MODE_W-1:0] = MANUAL_AUTO;
        d_stop[MODE_W-1:0] = STOP_CAP_HIGH;
        d_sec[0] = 1'b0;
      end
      default: begin
        case ($urandom_range(3))
          0: d_wb[WB_W-1:0] = '0;
          1: d_wb[WB_W-1:0] = '1;
          default: d_wb[WB_W-1:0] = WB_W'($urandom_range(16383));
        endcase
        case ($urandom_range(5))
          0: d_pct[PCT_W-1:0] = '0;
          1: d_pct[PCT_W-1:0] = 8'd200;
          2: d_pct[PCT_W-1:0] = '1;
          3: d_pct[PCT_W-1:0] = PERCENT_RST;
          default: d_pct[PCT_W-1:0] = PCT_W'($urandom_range(200));
        endcase
        if ($urandom_range(99) < 60) begin
          d_man[MODE_W-1:0] = MANUAL_AUTO;
        end else begin
          d_man[MODE_W-1:0] = MODE_W'($urandom_range(3, 1));
        end
        d_sec[0] = $urandom_range(99) < 15;
      end
    endcase
    write_reg(REG_WHEELBASE, d_wb);
    write_reg(REG_SPEED_PERCENT, d_pct);
    write_reg(REG_STOP_ANGLE, d_ang);
    write_reg(REG_MANUAL_MODE, d_man);
    write_reg(REG_STOP_MODE, d_stop);
    write_reg(REG_SECOND_STOP, d_sec);
    write_reg($urandom_range(1) ? REG_SPARE : REG_NONE, CFG_DATA_W'($urandom));
  endtask

  always @(negedge clk) begin
    res_if.ready <= $urandom_range(99) >= stall_pct;
  end

  always @(posedge clk) begin : check_results
    steer_result_t want;
    if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 0, res_if.wheel_speed);
      end else begin
        want = pending_results.pop_front();
        if (res_if.wheel_speed !== want.speed) begin
          report_mismatch("wheel_speed", want.speed, res_if.wheel_speed);
        end
        if (res_if.steer_angle !== want.angle) begin
          report_mismatch("steer_angle", want.angle, res_if.steer_angle);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("tricycle_steer_and_speed_unit test failed");
    $finish;
  end

  initial begin
    drill_row_t row;
    rst_n            = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.fwd_speed = '0;
    cmd_if.yaw_rate  = '0;
    res_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    fail_count       = 0;
    commands_sent    = 0;
    results_seen     = 0;
    writes_done      = 0;
    slow_turns       = 0;
    drive_regs = '{int'(WHEELBASE_RST), int'(PERCENT_RST), 0,
                   int'(MANUAL_MODE_RST), int'(STOP_MODE_RST), 0};

    add_known(16'sd0, 16'sd0, 16'sd0, 14'sd0);
    add_known(16'sd0, -16'sd32768, 16'sd0, 14'sd0);
    add_cmd(16'sd32767, 16'sd0);
    add_cmd(-16'sd32768, 16'sd0);
    add_cmd(16'sd32767, 16'sd32767);
    add_cmd(-16'sd32768, -16'sd32768);
    add_cmd(16'sd1, 16'sd32767);
    add_cmd(-16'sd1, -16'sd32768);
    add_cmd(16'sd4096, 16'sd4096);
    add_cmd(16'sd4096, 16'sd200);
    add_write(REG_WHEELBASE, 16'hFFFF);
    add_write(REG_SPEED_PERCENT, 16'd200);
    add_cmd(16'sd32767, 16'sd32767);
    add_cmd(-16'sd32768, 16'sd32767);
    add_write(REG_WHEELBASE, 16'h0000);
    add_write(REG_SPEED_PERCENT, 16'h0000);
    add_cmd(16'sd20000, 16'sd32767);
    add_write(REG_STOP_ANGLE, 16'h2000);
    add_known(16'sd0, 16'sd1234, 16'sd0, -14'sd8192);
    add_write(REG_STOP_ANGLE, 16'h1FFF);
    add_write(REG_SPEED_PERCENT, 16'h00FF);
    add_known(16'sd0, 16'sd5, 16'sd0, 14'sd8191);
    add_cmd(16'sd30000, -16'sd100);
    add_write(REG_WHEELBASE, 16'(WHEELBASE_RST));
    add_write(REG_SPEED_PERCENT, 16'(PERCENT_RST));
    add_write(REG_STOP_MODE, 16'(STOP_CAP_HIGH));
    add_cmd(16'sd8192, 16'sd1000);
    add_cmd(-16'sd8192, 16'sd1000);
    add_write(REG_STOP_MODE, 16'(STOP_CAP_LOW));
    add_cmd(16'sd8192, 16'sd0);
    add_write(REG_SPEED_PERCENT, 16'h0000);
    add_cmd(16'sd8192, 16'sd0);
    add_write(REG_SPEED_PERCENT, 16'(PERCENT_RST));
    add_write(REG_STOP_MODE, 16'(STOP_FULL));
    add_cmd(16'sd8192, 16'sd4096);
    add_write(REG_STOP_MODE, 16'(STOP_NONE));
    add_write(REG_SECOND_STOP, 16'h0001);
    add_cmd(16'sd8192, -16'sd4096);
    add_write(REG_MANUAL_MODE, 16'(MANUAL_FREE));
    add_cmd(16'sd8192, -16'sd4096);
    add_write(REG_MANUAL_MODE, 16'(MANUAL_SPARE));
    add_cmd(-16'sd8192, 16'sd4096);
    add_write(REG_MANUAL_MODE, 16'(MANUAL_FORCE));
    add_cmd(16'sd12000, 16'sd3000);
    add_known(16'sd0, 16'sd3000, 16'sd0, 14'sd8191);
    add_write(REG_NONE, 16'hFFFF);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (drill_rows[i]) begin
      row = drill_rows[i];
      if (row.is_write) begin
        wait_drained();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_cmd(row);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      program_segment(seg);
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        row = '0;
        row.fwd = pick_field(8);
        row.yaw = pick_field(5);
        send_cmd(row);
      end
    end

    wait_drained();
    repeat (LATENCY + 5) @(negedge clk);

    $display("Sent %0d requests and checked %0d results across %0d register writes.",
             commands_sent, results_seen, writes_done);
    $display("Slowed turns predicted: %0d; mismatches: %0d.", slow_turns, fail_count);
    if (fail_count == 0) begin
      $display("tricycle_steer_and_speed_unit test passed");
    end else begin
      $display("tricycle_steer_and_speed_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/tsu_pkg.sv
hw/rtl/tsu_if.sv
hw/rtl/tsu_prep.sv
hw/rtl/tsu_cordic.sv
hw/rtl/tsu_scale.sv
hw/rtl/tricycle_steer_and_speed_unit.sv
hw/rtl/tsu_checker.sv
dv/tricycle_steer_and_speed_unit_test.sv
